// ===== rtl/tmls_pkg.sv =====
package tmls_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned CFG_W   = 4;

  // count_wanted after reset
  localparam logic [CFG_W-1:0] COUNT_RESET = 4'd8;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      last_item;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] kept_value;
    logic [POS_W-1:0]          kept_position;
    logic                      slot_filled;
    logic                      final_rank;
  } out_word_t;

  // contents of one rank of the chain
  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      filled;
  } cell_data_t;

  // per-cycle command shared by every cell
  typedef struct packed {
    logic insert;
    logic shift_up;
    logic clear;
  } cell_ctl_t;

endpackage

// ===== rtl/top_m_largest_selector_unit.sv =====
// Top-M largest selector.
// Input channel: a word (sample_value, last_item) is taken at a rising edge
// where start is high and busy is low. Each word gets a position in its set,
// counting from 0 and saturating at SET_LIMIT-1.
// The largest count_wanted values are held in a row of TOP_COUNT cells,
// sorted in descending order; ties keep the earlier value ahead.
// Throughput: one word per cycle while no report runs. Each cell compares the
// new value with its own and hands its contents to its neighbour, so an
// insertion updates every cell together, whatever the depth.
// Report: the word marked last is inserted, then busy rises and count_wanted
// result words follow on result_o, one per cycle, marked by result_valid_o,
// starting the cycle after the accept. The report drains the row through
// rank 0, shifting every rank up towards it.
// The final result carries final_rank; the set state is then cleared and
// busy falls in the next cycle. The receiver cannot stall: each result word
// is present for exactly one cycle.
// Configuration: cfg_we_i writes count_wanted from cfg_wdata_i; 0 acts as 1,
// values above TOP_COUNT act as TOP_COUNT. Write only while idle.
// Reset: the row is empty, the position counter is zero, count_wanted is 8.
module top_m_largest_selector_unit #(
  parameter int unsigned TOP_COUNT = 8,
  parameter int unsigned SET_LIMIT = 65536
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  tmls_pkg::in_word_t         in_word_i,
  output logic                       result_valid_o,
  output tmls_pkg::out_word_t        result_o,
  input  logic                       cfg_we_i,
  input  logic [tmls_pkg::CFG_W-1:0] cfg_wdata_i
);

  localparam int unsigned CNT_W = (SET_LIMIT > 1) ? $clog2(SET_LIMIT) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(SET_LIMIT - 1);

  logic [tmls_pkg::CFG_W-1:0] cfg_q;
  logic [tmls_pkg::CFG_W-1:0] eff_count;
  logic [tmls_pkg::CFG_W-1:0] rank_q, rank_d;
  logic                       report_q, report_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       accept;
  logic                       final_rank;
  tmls_pkg::cell_ctl_t        ctl;
  tmls_pkg::cell_data_t       new_word;
  tmls_pkg::cell_data_t       cell_q [TOP_COUNT];
  logic [TOP_COUNT-1:0]       ins;
  logic [TOP_COUNT-1:0]       active;

  // hold the count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= tmls_pkg::COUNT_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // clamp the count into 1..TOP_COUNT
  always_comb begin
    if (cfg_q == '0) begin
      eff_count = tmls_pkg::CFG_W'(1);
    end else if (32'(cfg_q) > TOP_COUNT) begin
      eff_count = tmls_pkg::CFG_W'(TOP_COUNT);
    end else begin
      eff_count = cfg_q;
    end
  end

  assign accept     = start & ~busy;
  assign final_rank = report_q & (rank_q == eff_count - tmls_pkg::CFG_W'(1));

  assign ctl.insert   = accept;
  assign ctl.shift_up = report_q & ~final_rank;
  assign ctl.clear    = final_rank;

  assign new_word.value    = in_word_i.sample_value;
  assign new_word.position = 16'(cnt_q);
  assign new_word.filled   = 1'b1;

  // advance the position counter, saturating; restart on the last word
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (in_word_i.last_item) begin
        cnt_d = '0;
      end else if (cnt_q < CNT_MAX) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  // report sequencing: one rank per cycle after the last word
  always_comb begin
    report_d = report_q;
    rank_d   = rank_q;
    if (accept && in_word_i.last_item) begin
      report_d = 1'b1;
      rank_d   = '0;
    end else if (final_rank) begin
      report_d = 1'b0;
    end else if (report_q) begin
      rank_d = rank_q + tmls_pkg::CFG_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      report_q <= 1'b0;
      rank_q   <= '0;
    end else begin
      cnt_q    <= cnt_d;
      report_q <= report_d;
      rank_q   <= rank_d;
    end
  end

  // row of compare-and-shift cells
  for (genvar i = 0; i < TOP_COUNT; i++) begin : g_cell
    tmls_pkg::cell_data_t left_w;
    tmls_pkg::cell_data_t right_w;
    logic                 left_ins_w;

    assign active[i] = (32'(i) < 32'(eff_count));

    if (i == 0) begin : g_head
      assign left_w     = new_word;
      assign left_ins_w = 1'b0;
    end else begin : g_body
      assign left_w     = cell_q[i-1];
      assign left_ins_w = ins[i-1];
    end

    if (i == TOP_COUNT - 1) begin : g_tail
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_q[i+1];
    end

    tmls_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .active_i   (active[i]),
      .new_i      (new_word),
      .left_i     (left_w),
      .left_ins_i (left_ins_w),
      .right_i    (right_w),
      .ins_o      (ins[i]),
      .data_o     (cell_q[i])
    );
  end

  // drive the result word from rank 0, zero when empty
  assign busy                   = report_q;
  assign result_valid_o         = report_q;
  assign result_o.kept_value    = cell_q[0].filled ? cell_q[0].value : '0;
  assign result_o.kept_position = cell_q[0].filled ? cell_q[0].position : '0;
  assign result_o.slot_filled   = cell_q[0].filled;
  assign result_o.final_rank    = final_rank;

  // a report always ends with busy dropping
  a_final_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.final_rank |=> !busy)
    else $error("busy held after the final rank");

  // a last word always starts a report in the next cycle
  a_last_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && in_word_i.last_item |=> result_valid_o)
    else $error("no report after the last word");

  // a report is unbroken until its final rank
  a_report_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.final_rank |=> result_valid_o)
    else $error("report broke off early");

  // filled ranks form a prefix: no filled rank after an empty one
  a_filled_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.final_rank && !result_o.slot_filled
      |=> !result_o.slot_filled)
    else $error("filled rank after an empty rank");

endmodule

// ===== rtl/tmls_cell.sv =====
module tmls_cell (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tmls_pkg::cell_ctl_t    ctl_i,
  input  logic                   active_i,
  input  tmls_pkg::cell_data_t   new_i,
  input  tmls_pkg::cell_data_t   left_i,
  input  logic                   left_ins_i,
  input  tmls_pkg::cell_data_t   right_i,
  output logic                   ins_o,
  output tmls_pkg::cell_data_t   data_o
);

  logic                 filled_q, filled_d;
  logic signed [31:0]   value_q, value_d;
  logic [15:0]          pos_q, pos_d;

  // the new word belongs here or further up: this rank is empty or beaten
  assign ins_o = active_i & (~filled_q | ($signed(new_i.value) > $signed(value_q)));

  // pick the next contents of this rank
  always_comb begin
    filled_d = filled_q;
    value_d  = value_q;
    pos_d    = pos_q;
    if (ctl_i.clear) begin
      filled_d = 1'b0;
    end else if (ctl_i.shift_up) begin
      filled_d = right_i.filled;
      value_d  = right_i.value;
      pos_d    = right_i.position;
    end else if (ctl_i.insert) begin
      if (!active_i) begin
        filled_d = 1'b0;
      end else if (left_ins_i) begin
        filled_d = left_i.filled;
        value_d  = left_i.value;
        pos_d    = left_i.position;
      end else if (ins_o) begin
        filled_d = 1'b1;
        value_d  = new_i.value;
        pos_d    = new_i.position;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filled_q <= 1'b0;
    end else begin
      filled_q <= filled_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pos_q   <= pos_d;
  end

  assign data_o.value    = value_q;
  assign data_o.position = pos_q;
  assign data_o.filled   = filled_q;

endmodule

// ===== bench/tb_top_m_largest_selector_unit.sv =====
`timescale 1ns / 1ps

module tb_top_m_largest_selector_unit;

  localparam int unsigned TOP_COUNT = 8;
  localparam int unsigned SET_LIMIT = 32;
  // cycles for a report to finish and busy to fall after the last result
  localparam int SETTLE_CYCLES = TOP_COUNT + 4;
  localparam int IDLE_LIMIT    = 1000;
  localparam int MAX_GAP       = 14;
  localparam int LONG_SET_LEN  = SET_LIMIT + 4;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       start       = 1'b0;
  logic                       busy;
  tmls_pkg::in_word_t         sample_word = '0;
  logic                       result_valid_o;
  tmls_pkg::out_word_t        result_o;
  logic                       cfg_we_i    = 1'b0;
  logic [tmls_pkg::CFG_W-1:0] cfg_wdata_i = '0;

  // selector mirror: kept values and positions, fill level, position counter
  logic signed [tmls_pkg::VALUE_W-1:0] kept_values [TOP_COUNT];
  logic [tmls_pkg::POS_W-1:0]          kept_positions [TOP_COUNT];
  int                                  kept_fill;
  int                                  set_position;
  logic [tmls_pkg::CFG_W-1:0]          wanted_count;

  tmls_pkg::out_word_t expected_ranks [$];
  int                  mismatch_count = 0;
  int                  idle_cycles    = 0;

  top_m_largest_selector_unit #(
    .TOP_COUNT(TOP_COUNT),
    .SET_LIMIT(SET_LIMIT)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .in_word_i     (sample_word),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Insert one word into the mirror and queue the report it triggers
  task automatic insert_and_report(input tmls_pkg::in_word_t w);
    int                  eff;
    int                  slot;
    int                  last_slot;
    tmls_pkg::out_word_t rank;
    eff = int'(wanted_count);
    if (eff < 1) eff = 1;
    if (eff > TOP_COUNT) eff = TOP_COUNT;
    if (kept_fill > eff) kept_fill = eff;
    slot = 0;
    while (slot < kept_fill && !($signed(w.sample_value) > $signed(kept_values[slot])))
      slot++;
    if (slot < eff) begin
      last_slot = (kept_fill < eff) ? kept_fill : eff - 1;
      for (int i = last_slot; i > slot; i--) begin
        kept_values[i]    = kept_values[i-1];
        kept_positions[i] = kept_positions[i-1];
      end
      kept_values[slot]    = w.sample_value;
      kept_positions[slot] = tmls_pkg::POS_W'(set_position);
      if (kept_fill < eff) kept_fill++;
    end
    if (set_position < SET_LIMIT - 1) set_position++;
    if (w.last_item) begin
      for (int i = 0; i < eff; i++) begin
        rank.slot_filled   = (i < kept_fill);
        rank.kept_value    = rank.slot_filled ? kept_values[i] : '0;
        rank.kept_position = rank.slot_filled ? kept_positions[i] : '0;
        rank.final_rank    = (i + 1 == eff);
        expected_ranks.push_back(rank);
      end
      kept_fill    = 0;
      set_position = 0;
    end
  endtask

  function automatic tmls_pkg::in_word_t make_word(
      input logic signed [tmls_pkg::VALUE_W-1:0] v, input logic last);
    tmls_pkg::in_word_t w;
    w.sample_value = v;
    w.last_item    = last;
    return w;
  endfunction

  // Mix of full-range values, tie-heavy small values and extremes
  function automatic logic signed [tmls_pkg::VALUE_W-1:0] random_value();
    logic signed [tmls_pkg::VALUE_W-1:0] v;
    case ($urandom_range(4))
      0, 1: v = $urandom;
      2: v = 32'($urandom_range(6)) - 32'd3;
      3: v = $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: v = $urandom & 32'h8000_000f;
    endcase
    return v;
  endfunction

  // Send one word after a random gap; leave start high for the next word
  task automatic send_word(input tmls_pkg::in_word_t w, input int max_gap);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start       <= 1'b1;
    sample_word <= w;
    do @(posedge clk_i); while (busy);
    insert_and_report(w);
  endtask

  // Hold off the sender until every expected word has come and the block is quiet
  task automatic drain_results();
    start <= 1'b0;
    while (expected_ranks.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [tmls_pkg::CFG_W-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    wanted_count = v;
    cfg_we_i    <= 1'b0;
  endtask

  task automatic send_set(input int len, input int max_gap);
    for (int i = 0; i < len; i++)
      send_word(make_word(random_value(), i == len - 1), max_gap);
  endtask

  // Short set at the reset count: empty ranks, ties and a non-final word
  task automatic test_short_set();
    send_word(make_word(32'sd5, 1'b0), MAX_GAP);
    send_word(make_word(32'sd5, 1'b0), MAX_GAP);
    send_word(make_word(-32'sd7, 1'b1), MAX_GAP);
    drain_results();
  endtask

  // Extremes of the value field, and a set of a single word
  task automatic test_extremes();
    send_word(make_word(32'h8000_0000, 1'b0), 0);
    send_word(make_word(32'h7fff_ffff, 1'b0), 0);
    send_word(make_word(32'hffff_ffff, 1'b0), 0);
    send_word(make_word(32'h0000_0000, 1'b0), 0);
    send_word(make_word(32'h7fff_ffff, 1'b0), 0);
    send_word(make_word(32'h0000_0001, 1'b1), 0);
    send_word(make_word(32'h8000_0000, 1'b1), MAX_GAP);
    drain_results();
  endtask

  // Register below and above range, and the lowest legal count
  task automatic test_count_range();
    write_count(4'd0);
    send_set(3, MAX_GAP);
    drain_results();
    write_count(4'd15);
    send_set(2, MAX_GAP);
    drain_results();
    write_count(4'd1);
    send_set(2, 0);
    drain_results();
    write_count(4'd9);
    send_set(1, 0);
    drain_results();
  endtask

  // Lower the count between words of one set; ranks beyond it are lost
  task automatic test_count_lowered_mid_set();
    write_count(4'd8);
    send_word(make_word(32'sd10, 1'b0), MAX_GAP);
    send_word(make_word(32'sd40, 1'b0), MAX_GAP);
    send_word(make_word(32'sd20, 1'b0), MAX_GAP);
    send_word(make_word(32'sd30, 1'b0), MAX_GAP);
    send_word(make_word(32'sd50, 1'b0), MAX_GAP);
    drain_results();
    write_count(4'd3);
    send_word(make_word(32'sd25, 1'b0), MAX_GAP);
    send_word(make_word(32'sd5, 1'b1), MAX_GAP);
    drain_results();
  endtask

  // Long set: the position saturates, late maxima share the top position
  task automatic test_long_set();
    write_count(4'd4);
    for (int i = 0; i < LONG_SET_LEN; i++) begin
      if (i >= LONG_SET_LEN - 6)
        send_word(make_word(32'h7fff_ffff, i == LONG_SET_LEN - 1), 0);
      else
        send_word(make_word(random_value(), 1'b0), 0);
    end
    drain_results();
  endtask

  // Random sets over several counts, with and without idling
  task automatic test_random_sets();
    logic [tmls_pkg::CFG_W-1:0] phase_counts [7] = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd5, 4'd12};
    int sent;
    int len;
    int max_gap;
    for (int p = 0; p < 8; p++) begin
      write_count((p < 7) ? phase_counts[p] : tmls_pkg::CFG_W'($urandom_range(15)));
      sent = 0;
      while (sent < 32) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 13) : $urandom_range(12, 1);
        max_gap = (p % 3 == 2 || $urandom_range(3) == 0) ? 0 : MAX_GAP;
        send_set(len, max_gap);
        sent += len;
      end
      drain_results();
    end
  endtask

  // Compare each result word with the oldest expectation
  always @(posedge clk_i) begin : check_results
    tmls_pkg::out_word_t want;
    if (rst_ni && result_valid_o) begin
      if (expected_ranks.size() == 0) begin
        report_mismatch("unexpected result word", 64'(result_o), 64'd0);
      end else begin
        want = expected_ranks.pop_front();
        if (result_o.kept_value !== want.kept_value)
          report_mismatch("kept_value", 64'(result_o.kept_value), 64'(want.kept_value));
        if (result_o.kept_position !== want.kept_position)
          report_mismatch("kept_position", 64'(result_o.kept_position),
                          64'(want.kept_position));
        if (result_o.slot_filled !== want.slot_filled)
          report_mismatch("slot_filled", 64'(result_o.slot_filled), 64'(want.slot_filled));
        if (result_o.final_rank !== want.final_rank)
          report_mismatch("final_rank", 64'(result_o.final_rank), 64'(want.final_rank));
      end
    end
  end

  // Drop the run if no input word is taken for too long
  always @(posedge clk_i) begin
    if (start && !busy) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top_m_largest_selector_unit failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    kept_fill    = 0;
    set_position = 0;
    wanted_count = tmls_pkg::COUNT_RESET;
    for (int i = 0; i < TOP_COUNT; i++) begin
      kept_values[i]    = '0;
      kept_positions[i] = '0;
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_set();
    test_extremes();
    test_count_range();
    test_count_lowered_mid_set();
    test_long_set();
    test_random_sets();

    drain_results();
    if (mismatch_count == 0 && expected_ranks.size() == 0) begin
      $display("tb_top_m_largest_selector_unit passed");
    end else begin
      $display("tb_top_m_largest_selector_unit failed");
    end
    $finish;
  end

endmodule
